@@ design/assert_macros.svh @@
// Assertion macros shared by the datetime reader modules.
// No dependencies; expects a clock named clock and a reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/rtcdt_pkg.sv @@
// Shared types and constants for the three-wire RTC datetime reader.
// No dependencies; imported by every module of the block.
package rtcdt_pkg;

   // Number of bytes clocked in after the command
   localparam int READ_BYTES = 7;

   // Request codes
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_START = 1'b1;

   // Reset value of the command register (datetime read)
   localparam logic [7:0] CMD_RESET = 8'h65;

   // Pin codes: bit0 SCK, bit1 SIO, bit2 CS
   localparam logic [2:0] PINS_OFF    = 3'b000;
   localparam logic [2:0] LVL_CLK     = 3'b001;
   localparam logic [2:0] LVL_SEL     = 3'b100;
   localparam logic [2:0] LVL_CLK_SEL = 3'b101;
   localparam logic [2:0] DIR_CLK_SEL = 3'b101;
   localparam logic [2:0] DIR_ALL     = 3'b111;

   // Sequence step numbers
   localparam logic [7:0] STEP_PRE        = 8'd0;
   localparam logic [7:0] STEP_SELECT     = 8'd1;
   localparam logic [7:0] STEP_DRIVE      = 8'd2;
   localparam logic [7:0] STEP_CMD_FIRST  = 8'd3;
   localparam logic [7:0] STEP_CMD_LAST   = 8'd18;
   localparam logic [7:0] STEP_TURN       = 8'd19;
   localparam logic [7:0] STEP_READ_FIRST = 8'd20;
   localparam int         LAST_STEP_INT   = 20 + 16 * READ_BYTES - 1;
   localparam logic [7:0] STEP_LAST       = 8'(LAST_STEP_INT);

   // Byte positions of the datetime fields and the sanity check values
   localparam logic [2:0] BYTE_YEAR    = 3'd0;
   localparam logic [2:0] BYTE_MONTH   = 3'd1;
   localparam logic [2:0] BYTE_DAY     = 3'd2;
   localparam logic [2:0] BYTE_WEEKDAY = 3'd3;
   localparam logic [2:0] BYTE_HOUR    = 3'd4;
   localparam logic [2:0] BYTE_MINUTE  = 3'd5;
   localparam logic [2:0] BYTE_SECOND  = 3'd6;
   localparam logic [7:0] BYTE_ERASED  = 8'hFF;
   localparam logic [7:0] BYTE_ZERO    = 8'h00;

   typedef logic [READ_BYTES-1:0][7:0] byte_array_type;

   // Pin write of one tick from the sequencer
   typedef struct packed {
      logic [2:0] level;
      logic [2:0] direction;
      logic       done;
   } pins_type;

   // Decoded datetime
   typedef struct packed {
      logic       valid_res;
      logic [7:0] year;
      logic [7:0] month;
      logic [7:0] day;
      logic [7:0] weekday;
      logic [5:0] hour;
      logic [7:0] minute;
      logic [7:0] second;
   } date_type;

   // Full result transaction
   typedef struct packed {
      pins_type pins;
      date_type date;
   } rsp_type;

endpackage

@@ design/rtcdt_seq.sv @@
// Step sequencer: command register, step counter, shift register and byte store.
// Depends on rtcdt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rtcdt_seq import rtcdt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_wr_en,
   input  logic [7:0]     csr_wr_data,
   input  logic           fire,
   input  logic           req_type,
   input  logic           sio_bit,
   output pins_type       pins,
   output byte_array_type bytes_view
);

   logic           busy_ff, busy_in;
   logic [7:0]     step_ff, step_in;
   logic [7:0]     shift_ff, shift_in;
   logic [7:0]     cmd_ff;
   byte_array_type bytes_ff;

   logic       active;
   logic [7:0] s;
   logic [7:0] cmd_off;
   logic [7:0] rd_off;
   logic [2:0] cmd_sel;
   logic       cmd_bit;
   logic [6:0] bit_idx;
   logic       cap_en;
   logic [2:0] cap_idx;

   // Decode the current step into a pin write and the shift/capture updates
   always_comb begin
      active  = busy_ff | (req_type == REQ_START);
      s       = busy_ff ? step_ff : STEP_PRE;
      cmd_off = s - STEP_CMD_FIRST;
      rd_off  = s - STEP_READ_FIRST;
      cmd_sel = 3'd7 - cmd_off[3:1];
      cmd_bit = cmd_ff[cmd_sel];
      bit_idx = rd_off[7:1];
      cap_idx = bit_idx[5:3];

      pins.level     = PINS_OFF;
      pins.direction = PINS_OFF;
      shift_in       = shift_ff;
      cap_en         = 1'b0;

      if (active) begin
         case (s) inside
            STEP_PRE: begin
               pins.level     = LVL_CLK;
               pins.direction = DIR_CLK_SEL;
            end
            STEP_SELECT, STEP_TURN: begin
               pins.level     = LVL_CLK_SEL;
               pins.direction = DIR_CLK_SEL;
            end
            STEP_DRIVE: begin
               pins.level     = LVL_CLK_SEL;
               pins.direction = DIR_ALL;
            end
            [STEP_CMD_FIRST:STEP_CMD_LAST]: begin
               // MSB first, SCK low then high
               pins.level     = {1'b1, cmd_bit, cmd_off[0]};
               pins.direction = DIR_ALL;
            end
            default: begin
               // Read phase: sample SIO on the SCK-high tick, LSB first
               pins.direction = DIR_CLK_SEL;
               if (rd_off[0]) begin
                  pins.level = LVL_CLK_SEL;
                  shift_in   = {sio_bit, shift_ff[7:1]};
                  cap_en     = (bit_idx[2:0] == 3'd7) && (bit_idx[6:3] < 4'(READ_BYTES));
               end else begin
                  pins.level = LVL_SEL;
               end
            end
         endcase
      end

      pins.done = active && (s >= STEP_LAST);
   end

   // Advance or finish the sequence
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (active) begin
         if (pins.done) begin
            busy_in = 1'b0;
            step_in = STEP_PRE;
         end else begin
            busy_in = 1'b1;
            step_in = s + 8'd1;
         end
      end
   end

   // Forward the byte captured this tick so the final decode sees it
   always_comb begin
      for (int i = 0; i < READ_BYTES; i++) begin
         bytes_view[i] = (cap_en && cap_idx == 3'(i)) ? shift_in : bytes_ff[i];
      end
   end

   // Control state and command register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         step_ff  <= STEP_PRE;
         shift_ff <= 8'h00;
         cmd_ff   <= CMD_RESET;
      end else begin
         if (fire) begin
            busy_ff  <= busy_in;
            step_ff  <= step_in;
            shift_ff <= shift_in;
         end
         if (csr_wr_en) begin
            cmd_ff <= csr_wr_data;
         end
      end
   end

   // Received byte store, written before it is read
   always_ff @(posedge clock) begin
      if (fire && cap_en) begin
         bytes_ff[cap_idx] <= shift_in;
      end
   end

   `ASSERT_IMPL(a_idle_step_clear, !busy_ff, step_ff == STEP_PRE, "idle with nonzero step")
   `ASSERT_IMPL(a_step_in_range, busy_ff, step_ff <= STEP_LAST, "step past end of sequence")
   `ASSERT_NEXT(a_done_ends_read, fire && pins.done, !busy_ff && step_ff == STEP_PRE,
                "sequence did not end after done")
   `ASSERT_NEXT(a_step_advances, fire && active && !pins.done,
                busy_ff && step_ff == $past(s) + 8'd1, "step did not advance by one")

endmodule

@@ design/rtcdt_decode.sv @@
// Sanity check and BCD decode of the received datetime bytes.
// Depends on rtcdt_pkg.
module rtcdt_decode import rtcdt_pkg::*; (
   input  logic           done,
   input  byte_array_type bytes_in,
   output date_type       date
);

   // Arithmetic BCD: low nibble plus ten times the high nibble
   function automatic logic [7:0] bcd_value(input logic [7:0] b);
      return 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0}) + 8'(b[3:0]);
   endfunction

   logic       ok;
   logic [7:0] hour_full;

   always_comb begin
      ok = done && (bytes_in[BYTE_YEAR] != BYTE_ERASED) && (bytes_in[BYTE_MONTH] != BYTE_ZERO);
      hour_full = bcd_value({2'b00, bytes_in[BYTE_HOUR][5:0]});

      date.valid_res = ok;
      date.year      = ok ? bcd_value(bytes_in[BYTE_YEAR])    : 8'h00;
      date.month     = ok ? bcd_value(bytes_in[BYTE_MONTH])   : 8'h00;
      date.day       = ok ? bcd_value(bytes_in[BYTE_DAY])     : 8'h00;
      date.weekday   = ok ? bcd_value(bytes_in[BYTE_WEEKDAY]) : 8'h00;
      date.hour      = ok ? hour_full[5:0]                    : 6'h00;
      date.minute    = ok ? bcd_value(bytes_in[BYTE_MINUTE])  : 8'h00;
      date.second    = ok ? bcd_value(bytes_in[BYTE_SECOND])  : 8'h00;
   end

endmodule

@@ design/rtcdt_skid.sv @@
// Two-entry result buffer: output register plus skid register.
// Depends on rtcdt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rtcdt_skid import rtcdt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    main_valid_ff, skid_valid_ff;
   rsp_type main_ff, skid_ff;
   logic    push, pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign push      = in_valid && in_ready;
   assign pop       = main_valid_ff && out_ready;

   // Control: refill from skid first, otherwise take new transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_ff <= in_data;
         end else begin
            main_ff <= in_data;
         end
      end
   end

   `ASSERT_IMPL(a_skid_implies_main, skid_valid_ff, main_valid_ff, "skid full with empty output")
   `ASSERT_NEXT(a_main_held, main_valid_ff && !out_ready, main_valid_ff, "stalled result dropped")
   `ASSERT_NEXT(a_skid_held, skid_valid_ff && !out_ready, skid_valid_ff, "skid entry dropped")

endmodule

@@ design/rtc_three_wire_datetime_reader.sv @@
// Three-wire RTC datetime reader, top level.
// Depends on rtcdt_pkg, rtcdt_seq, rtcdt_decode and rtcdt_skid.
//
// Usage: each req transaction is one tick of a bit-banged three-wire waveform
// (SCK bit0, SIO bit1, CS bit2). req_type = 1 starts a read when idle; any other
// transaction is a plain tick. Each tick returns exactly one rsp transaction
// with the pin levels and output enables to drive, and req_sio_in is the SIO
// level sampled on that tick. A read takes 132 ticks: select, the command byte
// from csr_wr_data (reset 0x65) MSB first, turnaround, then seven bytes LSB
// first. The last tick carries rsp_done_res, the sanity check and the decoded
// date and time; all result fields are zero on other ticks.
// Each response is registered in the output register, or in the skid entry
// when the output stalls. Throughput: one transaction per cycle while req_ready
// is high, set by the single-pass step decode between sequencer and output.
// Stall: a two-entry output buffer holds results; req_ready drops only when
// both entries are full, and no result is lost or repeated.
// Reset: synchronous, active high; the sequencer goes idle, the command
// register returns to 0x65 and the output buffer empties.
// csr_wr_en writes the command register at once, with no handshake.
module rtc_three_wire_datetime_reader import rtcdt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_type,
   input  logic       req_sio_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_pin_level,
   output logic [2:0] rsp_pin_direction,
   output logic       rsp_done_res,
   output logic       rsp_valid_res,
   output logic [7:0] rsp_year,
   output logic [7:0] rsp_month,
   output logic [7:0] rsp_day,
   output logic [7:0] rsp_weekday,
   output logic [5:0] rsp_hour,
   output logic [7:0] rsp_minute,
   output logic [7:0] rsp_second
);

   logic           fire;
   pins_type       pins;
   byte_array_type bytes_view;
   date_type       date;
   rsp_type        rsp_next, rsp_out;

   assign fire = req_valid && req_ready;

   // Step sequencer
   rtcdt_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .req_type    (req_type),
      .sio_bit     (req_sio_in),
      .pins        (pins),
      .bytes_view  (bytes_view)
   );

   // Datetime check and decode
   rtcdt_decode u_decode (
      .done     (pins.done),
      .bytes_in (bytes_view),
      .date     (date)
   );

   assign rsp_next.pins = pins;
   assign rsp_next.date = date;

   // Output register with skid entry
   rtcdt_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (rsp_next),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_out)
   );

   assign rsp_pin_level     = rsp_out.pins.level;
   assign rsp_pin_direction = rsp_out.pins.direction;
   assign rsp_done_res      = rsp_out.pins.done;
   assign rsp_valid_res     = rsp_out.date.valid_res;
   assign rsp_year          = rsp_out.date.year;
   assign rsp_month         = rsp_out.date.month;
   assign rsp_day           = rsp_out.date.day;
   assign rsp_weekday       = rsp_out.date.weekday;
   assign rsp_hour          = rsp_out.date.hour;
   assign rsp_minute        = rsp_out.date.minute;
   assign rsp_second        = rsp_out.date.second;

endmodule
